@@ sv/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpt_pkg
// Types and constants shared by the cursor and panning tracker.
// ----------------------------------------------------------------------------
package cpt_pkg;

	// Width of every coordinate, size and register value.
	localparam int unsigned CoordW = 16;
	// Width of the configuration register index.
	localparam int unsigned CfgIdxW = 8;

	// Cursor bitmap size in pixels and the display start alignment mask.
	localparam logic [CoordW-1:0] CURSOR_SIZE    = 16'd64;
	localparam logic [CoordW-1:0] PAN_ALIGN_MASK = 16'd7;

	// Item kinds.
	localparam logic KIND_MOVE    = 1'b0;
	localparam logic KIND_HOTSPOT = 1'b1;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_DESKTOP_WIDTH  = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_DESKTOP_HEIGHT = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_VISIBLE_WIDTH  = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_VISIBLE_HEIGHT = 8'd3;

	// Reset values of the configuration registers.
	localparam logic [CoordW-1:0] RST_DESKTOP_WIDTH  = 16'd1024;
	localparam logic [CoordW-1:0] RST_DESKTOP_HEIGHT = 16'd768;
	localparam logic [CoordW-1:0] RST_VISIBLE_WIDTH  = 16'd1024;
	localparam logic [CoordW-1:0] RST_VISIBLE_HEIGHT = 16'd768;

	// Screen geometry as held in the configuration registers.
	typedef struct packed {
		logic [CoordW-1:0] desktop_width;
		logic [CoordW-1:0] desktop_height;
		logic [CoordW-1:0] visible_width;
		logic [CoordW-1:0] visible_height;
	} geom_t;

	// One input word.
	typedef struct packed {
		logic              kind;
		logic [CoordW-1:0] coord_x;
		logic [CoordW-1:0] coord_y;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [CoordW-1:0] view_start_x;
		logic [CoordW-1:0] view_start_y;
		logic              pan_moved;
		logic [CoordW-1:0] cursor_reg_x;
		logic [CoordW-1:0] cursor_reg_y;
	} result_t;

endpackage

@@ sv/cpt_intf.sv @@
// ----------------------------------------------------------------------------
// cpt_intf
// Handshake channels of the cursor and panning tracker.
// ----------------------------------------------------------------------------

// Input word channel.
interface cpt_item_if
	import cpt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [CoordW-1:0] coord_x;
	logic [CoordW-1:0] coord_y;

	modport source (output valid, kind, coord_x, coord_y, input ready);
	modport sink   (input valid, kind, coord_x, coord_y, output ready);
endinterface

// Result word channel.
interface cpt_result_if
	import cpt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CoordW-1:0] view_start_x;
	logic [CoordW-1:0] view_start_y;
	logic              pan_moved;
	logic [CoordW-1:0] cursor_reg_x;
	logic [CoordW-1:0] cursor_reg_y;

	modport source (output valid, view_start_x, view_start_y, pan_moved,
		cursor_reg_x, cursor_reg_y, input ready);
	modport sink   (input valid, view_start_x, view_start_y, pan_moved,
		cursor_reg_x, cursor_reg_y, output ready);
endinterface

// Configuration write channel.
interface cpt_cfg_if
	import cpt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CoordW-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/cpt_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cpt_cfg_regs
// Screen geometry registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module cpt_cfg_regs
	import cpt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cpt_cfg_if.sink   cfg,
	output geom_t     geom
);

	geom_t geom_q;

	// Writes are always taken; an unknown index is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.desktop_width  <= RST_DESKTOP_WIDTH;
			geom_q.desktop_height <= RST_DESKTOP_HEIGHT;
			geom_q.visible_width  <= RST_VISIBLE_WIDTH;
			geom_q.visible_height <= RST_VISIBLE_HEIGHT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DESKTOP_WIDTH:  geom_q.desktop_width  <= cfg.data;
				REG_DESKTOP_HEIGHT: geom_q.desktop_height <= cfg.data;
				REG_VISIBLE_WIDTH:  geom_q.visible_width  <= cfg.data;
				REG_VISIBLE_HEIGHT: geom_q.visible_height <= cfg.data;
				default: ;
			endcase
		end
	end

	assign geom = geom_q;

endmodule

@@ sv/cpt_core.sv @@
// ----------------------------------------------------------------------------
// cpt_core
// Pan and cursor state with the single-pass update logic for one word.
// ----------------------------------------------------------------------------
module cpt_core
	import cpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  geom_t   geom,
	input  item_t   item,
	input  logic    advance,
	output result_t result
);

	logic [CoordW-1:0] start_x_q, start_y_q;
	logic [CoordW-1:0] hotspot_x_q, hotspot_y_q;
	logic [CoordW-1:0] cur_x_q, cur_y_q;

	logic [CoordW-1:0] px, py;
	logic [CoordW:0]   edge_x, edge_y;
	logic [CoordW-1:0] hs_n, vs_n;
	logic              moved_x, moved_y;
	logic [CoordW-1:0] cur_x_n, cur_y_n;
	logic [CoordW-1:0] start_x_n, start_y_n;
	logic [CoordW-1:0] hotspot_x_n, hotspot_y_n;
	logic              pan_n;

	// Clamp the pointer to the virtual desktop.
	always_comb begin
		px = (item.coord_x >= geom.desktop_width) ?
			geom.desktop_width - 16'd1 : item.coord_x;
		py = (item.coord_y >= geom.desktop_height) ?
			geom.desktop_height - 16'd1 : item.coord_y;
	end

	// Window edges are compared one bit wider so the sum never wraps.
	assign edge_x = {1'b0, geom.visible_width}  + {1'b0, start_x_q};
	assign edge_y = {1'b0, geom.visible_height} + {1'b0, start_y_q};

	// Horizontal pan: round up when moving right, down when moving left.
	always_comb begin
		hs_n    = start_x_q;
		moved_x = 1'b0;
		priority if ({1'b0, px} >= edge_x) begin
			hs_n    = (px - geom.visible_width + 16'd1 + PAN_ALIGN_MASK) & ~PAN_ALIGN_MASK;
			moved_x = 1'b1;
		end else if (px < start_x_q) begin
			hs_n    = px & ~PAN_ALIGN_MASK;
			moved_x = 1'b1;
		end
	end

	// Vertical pan moves exactly as far as needed.
	always_comb begin
		vs_n    = start_y_q;
		moved_y = 1'b0;
		priority if ({1'b0, py} >= edge_y) begin
			vs_n    = py - geom.visible_height + 16'd1;
			moved_y = 1'b1;
		end else if (py < start_y_q) begin
			vs_n    = py;
			moved_y = 1'b1;
		end
	end

	// Select the next state for either kind of word.
	always_comb begin
		start_x_n   = start_x_q;
		start_y_n   = start_y_q;
		hotspot_x_n = hotspot_x_q;
		hotspot_y_n = hotspot_y_q;
		pan_n       = 1'b0;
		unique case (item.kind)
			KIND_MOVE: begin
				start_x_n = hs_n;
				start_y_n = vs_n;
				pan_n     = moved_x | moved_y;
				cur_x_n   = CURSOR_SIZE - hotspot_x_q + (px - hs_n);
				cur_y_n   = CURSOR_SIZE - hotspot_y_q + (py - vs_n);
			end
			KIND_HOTSPOT: begin
				cur_x_n     = cur_x_q + hotspot_x_q - item.coord_x;
				cur_y_n     = cur_y_q + hotspot_y_q - item.coord_y;
				hotspot_x_n = item.coord_x;
				hotspot_y_n = item.coord_y;
			end
			default: begin
				cur_x_n = cur_x_q;
				cur_y_n = cur_y_q;
			end
		endcase
	end

	// State advances once per word handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= '0;
			start_y_q   <= '0;
			hotspot_x_q <= '0;
			hotspot_y_q <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
		end else if (advance) begin
			start_x_q   <= start_x_n;
			start_y_q   <= start_y_n;
			hotspot_x_q <= hotspot_x_n;
			hotspot_y_q <= hotspot_y_n;
			cur_x_q     <= cur_x_n;
			cur_y_q     <= cur_y_n;
		end
	end

	always_comb begin
		result.view_start_x = start_x_n;
		result.view_start_y = start_y_n;
		result.pan_moved    = pan_n;
		result.cursor_reg_x = cur_x_n;
		result.cursor_reg_y = cur_y_n;
	end

endmodule

@@ sv/cursor_pan_position_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// cursor_pan_position_tracker_unit
// Cursor position and virtual-desktop panning unit.
// ----------------------------------------------------------------------------
// A word accepted into the input register passes through the update logic in
// the core and is registered in the result register when that is free or emptied.
// Throughput: one word per cycle while the result side keeps taking words,
// set by the single update pass on the pan and cursor state between the
// input and result registers. Reset clears the pan and cursor state and the
// valid flags, loads the default 1024 x 768 geometry and leaves the unit ready.
module cursor_pan_position_tracker_unit
	import cpt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	cpt_item_if.sink      in_item,
	cpt_result_if.source  out_res,
	cpt_cfg_if.sink       cfg
);

	geom_t   geom;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	// A word moves on when the result register is free or being emptied.
	assign advance       = valid_s1 & (~res_valid_q | out_res.ready);
	assign in_item.ready = ~valid_s1 | advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_item.ready) begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			item_s1.kind    <= in_item.kind;
			item_s1.coord_x <= in_item.coord_x;
			item_s1.coord_y <= in_item.coord_y;
		end
	end

	cpt_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.geom   (geom)
	);

	cpt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign out_res.valid        = res_valid_q;
	assign out_res.view_start_x = res_q.view_start_x;
	assign out_res.view_start_y = res_q.view_start_y;
	assign out_res.pan_moved    = res_q.pan_moved;
	assign out_res.cursor_reg_x = res_q.cursor_reg_x;
	assign out_res.cursor_reg_y = res_q.cursor_reg_y;

endmodule

@@ tb/cursor_pan_position_tracker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cursor_pan_position_tracker_unit_tb
// Self-checking bench for the cursor and panning tracker. Move and hot-spot
// words are driven with random gaps while the result side stalls at random.
// A tracker object keeps its own copy of the pan, hot-spot and cursor state
// and checks each result word, field by field, against the expected ones.
// ----------------------------------------------------------------------------
module cursor_pan_position_tracker_unit_tb;
	import cpt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CFG_IDX_TOP    = (1 << CfgIdxW) - 1;
	localparam int unsigned SETTLE_CYCLES  = 6;
	localparam int unsigned SQUEEZE_CYCLES = 120;
	localparam int unsigned SQUEEZE_WORDS  = 40;
	localparam int unsigned STALL_LIMIT    = 2000;
	localparam int unsigned RAND_PHASES    = 10;
	localparam int unsigned PHASE_WORDS    = 69;

	// Expected pan and cursor state, kept alongside the block.
	class pan_cursor_tracker;
		logic [CoordW-1:0] virt_w, virt_h, vis_w, vis_h;
		logic [CoordW-1:0] start_x, start_y, hot_x, hot_y, cur_x, cur_y;
		result_t           views_due[$];
		int unsigned       mismatches;

		function new();
			virt_w     = RST_DESKTOP_WIDTH;
			virt_h     = RST_DESKTOP_HEIGHT;
			vis_w      = RST_VISIBLE_WIDTH;
			vis_h      = RST_VISIBLE_HEIGHT;
			start_x    = '0;
			start_y    = '0;
			hot_x      = '0;
			hot_y      = '0;
			cur_x      = '0;
			cur_y      = '0;
			mismatches = 0;
		endfunction

		// Geometry register write; unmapped indexes are dropped.
		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
			case (idx)
				REG_DESKTOP_WIDTH: begin
					virt_w = val;
				end
				REG_DESKTOP_HEIGHT: begin
					virt_h = val;
				end
				REG_VISIBLE_WIDTH: begin
					vis_w = val;
				end
				REG_VISIBLE_HEIGHT: begin
					vis_h = val;
				end
				default: begin
				end
			endcase
		endfunction

		// Applies one accepted word and queues the view it must produce.
		function void take_item(item_t it);
			logic [CoordW-1:0] px, py, hs, vs;
			logic [CoordW:0]   right_x, bottom_y;
			result_t           view;

			view.pan_moved = 1'b0;
			if (it.kind == KIND_MOVE) begin
				px = it.coord_x;
				py = it.coord_y;
				hs = start_x;
				vs = start_y;
				// Clamp to the virtual desktop; a zero size wraps to all ones.
				if (px >= virt_w) begin
					px = virt_w - 16'd1;
				end
				if (py >= virt_h) begin
					py = virt_h - 16'd1;
				end
				// The window edge is compared one bit wider than the start.
				right_x  = {1'b0, vis_w} + {1'b0, hs};
				bottom_y = {1'b0, vis_h} + {1'b0, vs};
				if ({1'b0, px} >= right_x) begin
					hs = (px - vis_w + 16'd1 + PAN_ALIGN_MASK) & ~PAN_ALIGN_MASK;
					view.pan_moved = 1'b1;
				end else if (px < hs) begin
					hs = px & ~PAN_ALIGN_MASK;
					view.pan_moved = 1'b1;
				end
				if ({1'b0, py} >= bottom_y) begin
					vs = py - vis_h + 16'd1;
					view.pan_moved = 1'b1;
				end else if (py < vs) begin
					vs = py;
					view.pan_moved = 1'b1;
				end
				start_x = hs;
				start_y = vs;
				cur_x   = CURSOR_SIZE - hot_x + (px - hs);
				cur_y   = CURSOR_SIZE - hot_y + (py - vs);
			end else begin
				// A new hot spot shifts the cursor by old minus new.
				cur_x = cur_x + hot_x - it.coord_x;
				cur_y = cur_y + hot_y - it.coord_y;
				hot_x = it.coord_x;
				hot_y = it.coord_y;
			end
			view.view_start_x = start_x;
			view.view_start_y = start_y;
			view.cursor_reg_x = cur_x;
			view.cursor_reg_y = cur_y;
			views_due.push_back(view);
		endfunction

		function void compare_field(string field, logic [CoordW-1:0] want,
			logic [CoordW-1:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		// Checks one result word against the oldest expected view.
		function void check_view(result_t got);
			result_t want;

			if (views_due.size() == 0) begin
				mismatches++;
				$display("%0t: result word with none expected, got %p", $time, got);
			end else begin
				want = views_due.pop_front();
				compare_field("view_start_x", want.view_start_x, got.view_start_x);
				compare_field("view_start_y", want.view_start_y, got.view_start_y);
				compare_field("pan_moved", CoordW'(want.pan_moved), CoordW'(got.pan_moved));
				compare_field("cursor_reg_x", want.cursor_reg_x, got.cursor_reg_x);
				compare_field("cursor_reg_y", want.cursor_reg_y, got.cursor_reg_y);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic squeeze_req;
	int unsigned idle_cycles;

	pan_cursor_tracker tracker = new();

	cpt_item_if   item_ch ();
	cpt_result_if res_ch ();
	cpt_cfg_if    cfg_ch ();

	cursor_pan_position_tracker_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (item_ch),
		.out_res (res_ch),
		.cfg     (cfg_ch)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = ~clk;
	end

	// Sample every handshake and count cycles in which nothing moves.
	always @(posedge clk) begin
		item_t   seen_item;
		result_t seen_view;

		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				seen_item.kind    = item_ch.kind;
				seen_item.coord_x = item_ch.coord_x;
				seen_item.coord_y = item_ch.coord_y;
				tracker.take_item(seen_item);
			end
			if (res_ch.valid && res_ch.ready) begin
				seen_view.view_start_x = res_ch.view_start_x;
				seen_view.view_start_y = res_ch.view_start_y;
				seen_view.pan_moved    = res_ch.pan_moved;
				seen_view.cursor_reg_x = res_ch.cursor_reg_x;
				seen_view.cursor_reg_y = res_ch.cursor_reg_y;
				tracker.check_view(seen_view);
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				tracker.write_reg(cfg_ch.index, cfg_ch.data);
			end
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Watchdog: give up when no word has moved for too long.
	initial begin : watchdog
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random stalls, now and then a long hold-off.
	initial begin : result_sink
		int unsigned pick;

		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (squeeze_req) begin
				// Long hold-off so that the block fills and stalls its input.
				squeeze_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else if (pick < 2) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(30, 60)) @(posedge clk);
			end else if (pick < 35) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Gap before a word: mostly none or short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned pick;

		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// A value within spread units of a base, wrapping at 16 bits.
	function automatic logic [CoordW-1:0] near(logic [CoordW-1:0] base, int unsigned spread);
		return base + CoordW'($urandom_range(0, 2 * spread)) - CoordW'(spread);
	endfunction

	// Random word, aimed in part at the window edges.
	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;

		pick    = $urandom_range(0, 99);
		it.kind = ($urandom_range(0, 4) == 0) ? KIND_HOTSPOT : KIND_MOVE;
		if (it.kind == KIND_HOTSPOT) begin
			if (pick < 70) begin
				it.coord_x = CoordW'($urandom_range(0, CURSOR_SIZE - 1));
				it.coord_y = CoordW'($urandom_range(0, CURSOR_SIZE - 1));
			end else begin
				it.coord_x = CoordW'($urandom);
				it.coord_y = CoordW'($urandom);
			end
		end else if (pick < 30) begin
			it.coord_x = CoordW'($urandom);
			it.coord_y = CoordW'($urandom);
		end else if (pick < 65) begin
			it.coord_x = CoordW'($urandom_range(0, tracker.virt_w));
			it.coord_y = CoordW'($urandom_range(0, tracker.virt_h));
		end else if (pick < 85) begin
			it.coord_x = near(tracker.start_x + tracker.vis_w, 12);
			it.coord_y = near(tracker.start_y + tracker.vis_h, 4);
		end else begin
			it.coord_x = near(tracker.start_x, 12);
			it.coord_y = near(tracker.start_y, 4);
		end
		return it;
	endfunction

	// Random screen dimension, with the extremes well represented.
	function automatic logic [CoordW-1:0] random_dim();
		int unsigned pick;

		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			return '0;
		end else if (pick < 16) begin
			return 16'd1;
		end else if (pick < 26) begin
			return '1;
		end else if (pick < 40) begin
			return CoordW'($urandom);
		end
		return CoordW'($urandom_range(8, 2048));
	endfunction

	// Visible size, usually no larger than the virtual one.
	function automatic logic [CoordW-1:0] random_visible(logic [CoordW-1:0] virt);
		if (virt != 0 && $urandom_range(0, 9) < 7) begin
			return CoordW'($urandom_range(1, virt));
		end
		return random_dim();
	endfunction

	// Offer one word after a gap and wait for it to be taken. Valid stays
	// high afterwards so that back-to-back words need no second assignment.
	task automatic send_item(input logic kind, input logic [CoordW-1:0] x,
		input logic [CoordW-1:0] y, input int unsigned gap);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.kind    <= kind;
		item_ch.coord_x <= x;
		item_ch.coord_y <= y;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected view has come back.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (tracker.views_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four geometry registers plus one unmapped index.
	task automatic write_geometry(input logic [CoordW-1:0] vw, input logic [CoordW-1:0] vh,
		input logic [CoordW-1:0] sw, input logic [CoordW-1:0] sh);
		logic [CfgIdxW-1:0] idx[5];
		logic [CoordW-1:0]  val[5];

		idx = '{REG_DESKTOP_WIDTH, REG_DESKTOP_HEIGHT, REG_VISIBLE_WIDTH,
			REG_VISIBLE_HEIGHT, CfgIdxW'($urandom_range(CFG_IDX_TOP, REG_VISIBLE_HEIGHT + 1))};
		val = '{vw, vh, sw, sh, CoordW'($urandom)};
		for (int i = 0; i < 5; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			@(posedge clk);
			while (!cfg_ch.ready) begin
				@(posedge clk);
			end
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Main sequence: reset, directed words, then random phases.
	initial begin : stimulus
		item_t       it;
		logic [CoordW-1:0] vw, vh;
		bit          gapless;

		arst_n      = 1'b0;
		squeeze_req = 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.kind    <= KIND_MOVE;
		item_ch.coord_x <= '0;
		item_ch.coord_y <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_DESKTOP_WIDTH;
		cfg_ch.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: field extremes and hot-spot changes.
		send_item(KIND_MOVE, 16'd0, 16'd0, 0);
		send_item(KIND_MOVE, 16'hFFFF, 16'hFFFF, 0);
		send_item(KIND_HOTSPOT, 16'hFFFF, 16'hFFFF, 1);
		send_item(KIND_MOVE, 16'd100, 16'd200, 0);
		send_item(KIND_HOTSPOT, 16'd5, 16'd7, 0);
		send_item(KIND_HOTSPOT, 16'd0, 16'd0, 2);
		send_item(KIND_MOVE, 16'd1023, 16'd767, 0);
		wait_idle();

		// Window smaller than the desktop: pans right, left, down and up.
		write_geometry(16'd4096, 16'd2048, 16'd640, 16'd480);
		send_item(KIND_MOVE, 16'd1000, 16'd100, 0);
		send_item(KIND_MOVE, 16'd10, 16'd10, 0);
		send_item(KIND_MOVE, 16'd4095, 16'd2047, 0);
		send_item(KIND_HOTSPOT, 16'd3, 16'd60, 0);
		send_item(KIND_MOVE, 16'd0, 16'd0, 0);
		wait_idle();

		// Zero virtual size: the clamp lands on the top coordinate.
		write_geometry(16'd0, 16'd0, 16'd100, 16'd100);
		send_item(KIND_MOVE, 16'd5, 16'd5, 0);
		send_item(KIND_MOVE, 16'd0, 16'd0, 0);
		wait_idle();

		// Right pan past the top wraps the start, even back to its old value.
		write_geometry(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
		send_item(KIND_MOVE, 16'd0, 16'd0, 0);
		send_item(KIND_MOVE, 16'hFFFE, 16'hFFFE, 0);
		send_item(KIND_MOVE, 16'hFFFF, 16'd0, 0);
		wait_idle();

		// Visible area larger than the desktop.
		write_geometry(16'd100, 16'd50, 16'hFFFF, 16'hFFFF);
		send_item(KIND_MOVE, 16'd200, 16'd200, 0);
		send_item(KIND_MOVE, 16'd0, 16'd0, 0);
		send_item(KIND_MOVE, 16'd99, 16'd49, 0);
		wait_idle();

		// Random phases, each under a fresh geometry.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				1: begin
					write_geometry('1, '1, '1, '1);
				end
				2: begin
					write_geometry(16'd1, 16'd1, 16'd1, 16'd1);
				end
				3: begin
					write_geometry(RST_DESKTOP_WIDTH, RST_DESKTOP_HEIGHT,
						RST_VISIBLE_WIDTH, RST_VISIBLE_HEIGHT);
				end
				default: begin
					vw = random_dim();
					vh = random_dim();
					write_geometry(vw, vh, random_visible(vw), random_visible(vh));
				end
			endcase
			if (phase == 0) begin
				// Keep offering words while the result side is held off.
				squeeze_req = 1'b1;
				for (int n = 0; n < SQUEEZE_WORDS; n++) begin
					it = random_item();
					send_item(it.kind, it.coord_x, it.coord_y, 0);
				end
			end
			gapless = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				it = random_item();
				send_item(it.kind, it.coord_x, it.coord_y, gapless ? 0 : pick_gap());
			end
			wait_idle();
		end

		if (tracker.mismatches == 0 && tracker.views_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ cursor_pan_position_tracker_unit.f @@
sv/cpt_pkg.sv
sv/cpt_intf.sv
sv/cpt_cfg_regs.sv
sv/cpt_core.sv
sv/cursor_pan_position_tracker_unit.sv
tb/cursor_pan_position_tracker_unit_tb.sv
